@@ rtl/core/ecd_pkg.sv @@
// ecd_pkg: sizes, link record, sequencer types and helpers for the
// exchange gain cycle detector. No dependencies; every rtl/core file but ecd_ram uses it.
`default_nettype none
package ecd_pkg;

    localparam int MAX_CURRENCIES = 128;
    localparam int MAX_LINKS      = 256;

    // field widths fixed by the interface
    localparam int NODE_W     = 7;
    localparam int AMT_W      = 32;
    localparam int RATE_W     = 24;
    localparam int FEE_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 8;
    localparam int START_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // derived sizes
    localparam int NCUR_W  = $clog2(MAX_CURRENCIES + 1);
    localparam int CMP_W   = (NCUR_W > CNT_W) ? NCUR_W : CNT_W;
    localparam int AMT_AW  = $clog2(MAX_CURRENCIES);
    localparam int LINK_AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LINKS_W = $clog2(MAX_LINKS + 1);
    localparam int PROD_W  = AMT_W + RATE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUR_COUNT = 2'd0,
        CFG_START     = 2'd1,
        CFG_INIT_AMT  = 2'd2
    } t_cfg_idx;

    // one stored link: both directions
    typedef struct packed {
        logic [NODE_W-1:0] first;
        logic [NODE_W-1:0] second;
        logic [RATE_W-1:0] fwd_rate;
        logic [FEE_W-1:0]  fwd_fee;
        logic [RATE_W-1:0] bwd_rate;
        logic [FEE_W-1:0]  bwd_fee;
    } t_link;

    localparam int LINK_REC_W = $bits(t_link);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_PASS,
        S_LINK_RD,
        S_FROM_RD,
        S_TO_RD,
        S_MUL,
        S_CMP,
        S_EMIT
    } t_state;

    // sequencer -> datapath
    typedef struct packed {
        logic               busy;
        logic               seed;
        logic               link_re;
        logic [LINK_AW-1:0] link_addr;
        logic               dir;
        logic               from_re;
        logic               to_re;
        logic               mul_go;
        logic               amt_we;
        logic               emit;
        logic               gain;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic               relax;
        logic               out_busy;
        logic [NCUR_W-1:0]  ncur;
        logic [LINKS_W-1:0] links;
    } t_stat;

    // currency count clamped to the store size
    function automatic logic [NCUR_W-1:0] eff_count(input logic [CNT_W-1:0] count);
        logic [CMP_W-1:0] c;
        c = CMP_W'(count);
        if (c > CMP_W'(MAX_CURRENCIES)) begin
            return NCUR_W'(MAX_CURRENCIES);
        end
        return NCUR_W'(c);
    endfunction

    function automatic logic in_range(input logic [NODE_W-1:0] node,
                                      input logic [NCUR_W-1:0] ncur);
        return CMP_W'(node) < CMP_W'(ncur);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ecd_ram.sv @@
// ecd_ram: generic single-write, single-read RAM with registered read data.
// Standalone; used for the link store and the amount table.
`default_nettype none
module ecd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/core/ecd_relax.sv @@
// ecd_relax: shared relaxation unit: (amount - fee) * rate, Q16 truncate,
// saturate, compare against the destination amount. Uses ecd_pkg.
`default_nettype none
module ecd_relax (
    input  wire logic                      i_clk,
    input  wire logic                      i_go,
    input  wire logic [ecd_pkg::AMT_W-1:0]  i_from_amt,
    input  wire logic [ecd_pkg::FEE_W-1:0]  i_fee,
    input  wire logic [ecd_pkg::RATE_W-1:0] i_rate,
    input  wire logic [ecd_pkg::AMT_W-1:0]  i_to_amt,
    output logic                           o_relax,
    output logic      [ecd_pkg::AMT_W-1:0]  o_cand
);
    import ecd_pkg::*;

    localparam int HI_W = PROD_W - FRAC_W;

    logic              r_ok;
    logic [PROD_W-1:0] r_prod;
    logic [AMT_W-1:0]  diff;
    logic [HI_W-1:0]   hi;

    assign diff = i_from_amt - AMT_W'(i_fee);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_ok   <= i_from_amt > AMT_W'(i_fee);
            r_prod <= PROD_W'(diff) * PROD_W'(i_rate);
        end
    end

    assign hi      = r_prod[PROD_W-1:FRAC_W];
    assign o_cand  = (|hi[HI_W-1:AMT_W]) ? {AMT_W{1'b1}} : hi[AMT_W-1:0];
    assign o_relax = r_ok && (o_cand > i_to_amt);

endmodule
`default_nettype wire

@@ rtl/core/ecd_ctrl.sv @@
// ecd_ctrl: pass/edge sequencer for the relaxation runs.
// Uses ecd_pkg (t_state, t_ctrl, t_stat).
`default_nettype none
module ecd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire ecd_pkg::t_stat i_stat,
    output ecd_pkg::t_ctrl      o_ctrl
);
    import ecd_pkg::*;

    t_state             r_state, n_state;
    logic [LINK_AW-1:0] r_link, n_link;
    logic               r_dir, n_dir;
    logic [NCUR_W-1:0]  r_pass, n_pass;
    logic               r_final, n_final;
    logic               r_changed, n_changed;
    logic               r_gain, n_gain;
    logic               last_link;

    assign last_link = (LINKS_W'(r_link) + LINKS_W'(1)) == i_stat.links;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_link    <= '0;
            r_dir     <= 1'b0;
            r_pass    <= '0;
            r_final   <= 1'b0;
            r_changed <= 1'b0;
            r_gain    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_link    <= n_link;
            r_dir     <= n_dir;
            r_pass    <= n_pass;
            r_final   <= n_final;
            r_changed <= n_changed;
            r_gain    <= n_gain;
        end
    end

    // next state and counters
    always_comb begin
        n_state   = r_state;
        n_link    = r_link;
        n_dir     = r_dir;
        n_pass    = r_pass;
        n_final   = r_final;
        n_changed = r_changed;
        n_gain    = r_gain;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SEED;
            end
            S_SEED: begin
                n_pass  = NCUR_W'(1);
                n_final = i_stat.ncur <= NCUR_W'(1);
                n_gain  = 1'b0;
                n_state = S_PASS;
            end
            S_PASS: begin
                n_link    = '0;
                n_dir     = 1'b0;
                n_changed = 1'b0;
                // no edges: nothing can relax
                n_state   = (i_stat.links == '0) ? S_EMIT : S_LINK_RD;
            end
            S_LINK_RD: n_state = S_FROM_RD;
            S_FROM_RD: n_state = S_TO_RD;
            S_TO_RD:   n_state = S_MUL;
            S_MUL:     n_state = S_CMP;
            S_CMP: begin
                if (i_stat.relax && r_final) begin
                    n_gain  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    if (i_stat.relax) n_changed = 1'b1;
                    if (!r_dir) begin
                        n_dir   = 1'b1;
                        n_state = S_FROM_RD;
                    end else if (last_link) begin
                        if (r_final) begin
                            n_state = S_EMIT;
                        end else if (!(r_changed || i_stat.relax) ||
                                     (r_pass + NCUR_W'(1)) >= i_stat.ncur) begin
                            n_final = 1'b1;
                            n_state = S_PASS;
                        end else begin
                            n_pass  = r_pass + NCUR_W'(1);
                            n_state = S_PASS;
                        end
                    end else begin
                        n_link  = r_link + LINK_AW'(1);
                        n_dir   = 1'b0;
                        n_state = S_LINK_RD;
                    end
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // strobes to the datapath
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.busy      = r_state != S_IDLE;
        o_ctrl.link_addr = r_link;
        o_ctrl.dir       = r_dir;
        o_ctrl.gain      = r_gain;
        unique case (r_state)
            S_SEED:    o_ctrl.seed    = 1'b1;
            S_LINK_RD: o_ctrl.link_re = 1'b1;
            S_FROM_RD: o_ctrl.from_re = 1'b1;
            S_TO_RD:   o_ctrl.to_re   = 1'b1;
            S_MUL:     o_ctrl.mul_go  = 1'b1;
            S_CMP:     o_ctrl.amt_we  = i_stat.relax && !r_final;
            S_EMIT:    o_ctrl.emit    = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/exchange_gain_cycle_detect.sv @@
// Exchange gain cycle detector: link store, amount table, sequencer and
// shared relaxation unit. Uses ecd_pkg, ecd_ram, ecd_relax, ecd_ctrl.
// Throughput: a link beat without the last flag is taken every cycle while no run is in progress.
// A last-link beat starts a run that seeds the start amount and then runs P passes over the
// L links stored, P = passes run (the final check plus at most count - 1
// relaxation passes); each link uses the one amount-table port and the multiplier in both directions.
// Reset: sequencer idle, link count and amount valid bits cleared,
// registers back to count 1, start 0, amount 0; link store is not cleared.
`default_nettype none
module exchange_gain_cycle_detect (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ecd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ecd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [ecd_pkg::NODE_W-1:0]     i_first_currency,
    input  wire logic [ecd_pkg::NODE_W-1:0]     i_second_currency,
    input  wire logic [ecd_pkg::RATE_W-1:0]     i_forward_rate,
    input  wire logic [ecd_pkg::FEE_W-1:0]      i_forward_fee,
    input  wire logic [ecd_pkg::RATE_W-1:0]     i_backward_rate,
    input  wire logic [ecd_pkg::FEE_W-1:0]      i_backward_fee,
    input  wire logic                          i_last_link,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_gain_possible
);
    import ecd_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    logic [CNT_W-1:0]   r_cur_count;
    logic [START_W-1:0] r_start;
    logic [AMT_W-1:0]   r_init_amt;
    logic [LINKS_W-1:0] r_links;
    logic               r_out_valid;
    logic               r_out_gain;
    logic               r_amt_vld [MAX_CURRENCIES];
    logic               r_rd_vld;
    logic [AMT_W-1:0]   r_from_amt;
    logic [AMT_W-1:0]   r_to_amt;

    logic               accept;
    logic               store_link;
    logic [NCUR_W-1:0]  ncur;
    logic               seed_ok;
    t_link              link_in;
    t_link              link_q;
    logic [LINK_REC_W-1:0] link_rdata;
    logic [NODE_W-1:0]  from_node, to_node;
    logic [RATE_W-1:0]  rate;
    logic [FEE_W-1:0]   fee;
    logic               edge_ok;
    logic               amt_re, amt_we;
    logic [AMT_AW-1:0]  amt_raddr, amt_waddr;
    logic [AMT_W-1:0]   amt_wdata, amt_rdata, amt_q;
    logic               unit_relax;
    logic [AMT_W-1:0]   cand;

    assign accept     = i_valid && !o_stall;
    assign store_link = accept && (r_links < LINKS_W'(MAX_LINKS));
    assign ncur       = eff_count(r_cur_count);
    assign seed_ok    = in_range(NODE_W'(r_start), ncur);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_count <= CNT_W'(1);
            r_start     <= '0;
            r_init_amt  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CUR_COUNT: r_cur_count <= i_cfg_data[CNT_W-1:0];
                CFG_START:     r_start     <= i_cfg_data[START_W-1:0];
                CFG_INIT_AMT:  r_init_amt  <= i_cfg_data[AMT_W-1:0];
                default: ;
            endcase
        end
    end

    // link store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_links <= '0;
        end else if (ctrl.emit) begin
            r_links <= '0;
        end else if (store_link) begin
            r_links <= r_links + LINKS_W'(1);
        end
    end

    assign link_in = '{first:    i_first_currency,
                       second:   i_second_currency,
                       fwd_rate: i_forward_rate,
                       fwd_fee:  i_forward_fee,
                       bwd_rate: i_backward_rate,
                       bwd_fee:  i_backward_fee};

    ecd_ram #(
        .WIDTH (LINK_REC_W),
        .DEPTH (MAX_LINKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (store_link),
        .i_waddr (LINK_AW'(r_links)),
        .i_wdata (link_in),
        .i_re    (ctrl.link_re),
        .i_raddr (ctrl.link_addr),
        .o_rdata (link_rdata)
    );

    assign link_q    = t_link'(link_rdata);
    assign from_node = ctrl.dir ? link_q.second   : link_q.first;
    assign to_node   = ctrl.dir ? link_q.first    : link_q.second;
    assign rate      = ctrl.dir ? link_q.bwd_rate : link_q.fwd_rate;
    assign fee       = ctrl.dir ? link_q.bwd_fee  : link_q.fwd_fee;
    assign edge_ok   = in_range(from_node, ncur) && in_range(to_node, ncur);

    // amount table: one port pair, valid bits stand in for the per-run clear
    assign amt_re    = ctrl.from_re || ctrl.to_re;
    assign amt_raddr = ctrl.to_re ? AMT_AW'(to_node) : AMT_AW'(from_node);
    assign amt_we    = (ctrl.seed && seed_ok) || ctrl.amt_we;
    assign amt_waddr = ctrl.seed ? AMT_AW'(r_start) : AMT_AW'(to_node);
    assign amt_wdata = ctrl.seed ? r_init_amt : cand;

    ecd_ram #(
        .WIDTH (AMT_W),
        .DEPTH (MAX_CURRENCIES)
    ) u_amt_ram (
        .i_clk   (i_clk),
        .i_we    (amt_we),
        .i_waddr (amt_waddr),
        .i_wdata (amt_wdata),
        .i_re    (amt_re),
        .i_raddr (amt_raddr),
        .o_rdata (amt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amt_vld <= '{default: 1'b0};
            r_rd_vld  <= 1'b0;
        end else begin
            // a new run forgets every amount but the seeded start
            if (ctrl.seed) begin
                for (int i = 0; i < MAX_CURRENCIES; i++) begin
                    r_amt_vld[i] <= seed_ok && (AMT_AW'(i) == AMT_AW'(r_start));
                end
            end else if (amt_we) begin
                r_amt_vld[amt_waddr] <= 1'b1;
            end
            if (amt_re) r_rd_vld <= r_amt_vld[amt_raddr];
        end
    end

    assign amt_q = r_rd_vld ? amt_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (ctrl.to_re)  r_from_amt <= amt_q;
        if (ctrl.mul_go) r_to_amt   <= amt_q;
    end

    ecd_relax u_relax (
        .i_clk      (i_clk),
        .i_go       (ctrl.mul_go),
        .i_from_amt (r_from_amt),
        .i_fee      (fee),
        .i_rate     (rate),
        .i_to_amt   (r_to_amt),
        .o_relax    (unit_relax),
        .o_cand     (cand)
    );

    assign stat = '{relax:    edge_ok && unit_relax,
                    out_busy: r_out_valid && i_stall,
                    ncur:     ncur,
                    links:    r_links};

    ecd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && i_last_link),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) r_out_gain <= ctrl.gain;
    end

    assign o_stall         = ctrl.busy;
    assign o_valid         = r_out_valid;
    assign o_gain_possible = r_out_gain;

endmodule
`default_nettype wire

@@ rtl/core/ecd_checker.sv @@
// ecd_checker: port-level assertions for exchange_gain_cycle_detect, bound
// to the top level below. Uses ecd_pkg for port widths.
`default_nettype none
module ecd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_we,
    input wire logic [ecd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [ecd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic [ecd_pkg::NODE_W-1:0]     i_first_currency,
    input wire logic [ecd_pkg::NODE_W-1:0]     i_second_currency,
    input wire logic [ecd_pkg::RATE_W-1:0]     i_forward_rate,
    input wire logic [ecd_pkg::FEE_W-1:0]      i_forward_fee,
    input wire logic [ecd_pkg::RATE_W-1:0]     i_backward_rate,
    input wire logic [ecd_pkg::FEE_W-1:0]      i_backward_fee,
    input wire logic                          i_last_link,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic                          o_gain_possible
);

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_gain_possible))
        else $error("result beat changed while stalled");

    // the last link starts a run, so the input side stalls next
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_link |=> o_stall)
        else $error("no run after last link");

    // plain link beats load back to back
    a_load_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_last_link |=> !o_stall)
        else $error("stall after a plain link beat");

    // a result only comes out of a run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a run");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");

endmodule

bind exchange_gain_cycle_detect ecd_checker u_ecd_checker (.*);
`default_nettype wire

@@ sim/cycle_gain_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard for the exchange gain cycle detector: link store, register copy
// and a longest-path relaxation predictor. Depends on ecd_pkg for types and sizes.
package cycle_gain_sb_pkg;
    import ecd_pkg::*;

    class cycle_gain_scoreboard;
        // both directions of every stored link, in load order
        logic [NODE_W-1:0] src_of  [2*MAX_LINKS];
        logic [NODE_W-1:0] dst_of  [2*MAX_LINKS];
        logic [RATE_W-1:0] rate_of [2*MAX_LINKS];
        logic [FEE_W-1:0]  fee_of  [2*MAX_LINKS];
        logic [AMT_W-1:0]  balance [MAX_CURRENCIES];
        int unsigned       links_held;

        logic [CNT_W-1:0]   cfg_count;
        logic [START_W-1:0] cfg_start;
        logic [AMT_W-1:0]   cfg_amount;

        bit          gain_due[$];
        int unsigned mismatches;
        int unsigned runs_checked;
        int unsigned gain_runs;
        int unsigned links_taken;

        function new();
            links_held = 0;
            cfg_count  = 8'd1;
            cfg_start  = '0;
            cfg_amount = '0;
            mismatches = 0;
            runs_checked = 0;
            gain_runs  = 0;
            links_taken = 0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CUR_COUNT: cfg_count  = data[CNT_W-1:0];
                CFG_START:     cfg_start  = data[START_W-1:0];
                CFG_INIT_AMT:  cfg_amount = data[AMT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return gain_due.size();
        endfunction

        // amount edge e would offer its far end; 0 if it cannot relax at all
        function bit edge_offer(int unsigned e, int unsigned ncur,
                                output logic [NODE_W-1:0] to, output logic [63:0] offer);
            logic [AMT_W-1:0] have;
            logic [63:0]      diff;
            offer = '0;
            to    = dst_of[e];
            if (src_of[e] >= ncur || dst_of[e] >= ncur) return 1'b0;
            have = balance[src_of[e]];
            if (have <= fee_of[e]) return 1'b0;
            diff  = 64'(have - fee_of[e]);
            offer = (diff * 64'(rate_of[e])) >> FRAC_W;
            if (offer > 64'hFFFF_FFFF) offer = 64'hFFFF_FFFF;
            return 1'b1;
        endfunction

        function void take_link(t_link beat, logic last);
            int unsigned       k;
            int unsigned       ncur;
            int unsigned       nedges;
            int unsigned       pass;
            int unsigned       e;
            bit                grew;
            bit                gain;
            logic [NODE_W-1:0] to;
            logic [63:0]       offer;

            links_taken++;
            // a full store drops the link but still honors the last flag
            if (links_held < MAX_LINKS) begin
                k = 2 * links_held;
                src_of[k]    = beat.first;
                dst_of[k]    = beat.second;
                rate_of[k]   = beat.fwd_rate;
                fee_of[k]    = beat.fwd_fee;
                src_of[k+1]  = beat.second;
                dst_of[k+1]  = beat.first;
                rate_of[k+1] = beat.bwd_rate;
                fee_of[k+1]  = beat.bwd_fee;
                links_held++;
            end
            if (!last) return;

            ncur = (cfg_count > MAX_CURRENCIES) ? MAX_CURRENCIES : cfg_count;
            nedges = 2 * links_held;
            foreach (balance[i]) balance[i] = '0;
            if (cfg_start < ncur) balance[cfg_start] = cfg_amount;

            for (pass = 1; pass < ncur; pass++) begin
                grew = 1'b0;
                for (e = 0; e < nedges; e++) begin
                    if (edge_offer(e, ncur, to, offer) && 64'(balance[to]) < offer) begin
                        balance[to] = offer[AMT_W-1:0];
                        grew = 1'b1;
                    end
                end
                if (!grew) break;
            end

            gain = 1'b0;
            for (e = 0; e < nedges; e++) begin
                if (edge_offer(e, ncur, to, offer) && 64'(balance[to]) < offer) gain = 1'b1;
            end
            gain_due.push_back(gain);
            links_held = 0;
        endfunction

        function void check_gain(logic gain);
            bit want;
            runs_checked++;
            if (gain_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %0d with no run pending: gain_possible=%b",
                             runs_checked, gain);
                return;
            end
            want = gain_due.pop_front();
            if (gain !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("run %0d: gain_possible expected %0d, got %b",
                             runs_checked, want, gain);
            end else if (want) begin
                gain_runs++;
            end
        endfunction
    endclass

endpackage

@@ sim/tb_exchange_gain_cycle_detect.sv @@
`timescale 1ns / 100ps
// Testbench top for exchange_gain_cycle_detect: directed graphs, then random
// graphs with idles and stalls on both sides. Depends on ecd_pkg, cycle_gain_sb_pkg.
module tb_exchange_gain_cycle_detect;
    import ecd_pkg::*;
    import cycle_gain_sb_pkg::*;

    localparam int TIMEOUT_NS    = 8_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_LINKS  = 900;

    localparam logic [RATE_W-1:0] RATE_0_4 = 24'h006666;
    localparam logic [RATE_W-1:0] RATE_0_5 = 24'h008000;
    localparam logic [RATE_W-1:0] RATE_0_6 = 24'h00999A;
    localparam logic [RATE_W-1:0] RATE_0_75 = 24'h00C000;
    localparam logic [RATE_W-1:0] RATE_0_9 = 24'h00E666;
    localparam logic [RATE_W-1:0] RATE_1_0 = 24'h010000;
    localparam logic [RATE_W-1:0] RATE_1_1 = 24'h011999;
    localparam logic [RATE_W-1:0] RATE_1_5 = 24'h018000;
    localparam logic [RATE_W-1:0] RATE_2_0 = 24'h020000;
    localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;

    typedef enum int {
        RATES_LOSSY,
        RATES_NEAR_UNITY,
        RATES_WILD
    } t_rate_style;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [NODE_W-1:0]       i_first_currency = '0;
    logic [NODE_W-1:0]       i_second_currency = '0;
    logic [RATE_W-1:0]       i_forward_rate = '0;
    logic [FEE_W-1:0]        i_forward_fee = '0;
    logic [RATE_W-1:0]       i_backward_rate = '0;
    logic [FEE_W-1:0]        i_backward_fee = '0;
    logic                    i_last_link = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_gain_possible;

    cycle_gain_scoreboard sb;
    bit                   quiet = 1'b0;
    logic [CNT_W-1:0]     cur_count = 8'd1;
    int unsigned          cfg_rounds = 0;

    exchange_gain_cycle_detect dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_first_currency  (i_first_currency),
        .i_second_currency (i_second_currency),
        .i_forward_rate    (i_forward_rate),
        .i_forward_fee     (i_forward_fee),
        .i_backward_rate   (i_backward_rate),
        .i_backward_fee    (i_backward_fee),
        .i_last_link       (i_last_link),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_gain_possible   (o_gain_possible)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end

    // values read here are the ones present just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_gain(o_gain_possible);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("exchange_gain_cycle_detect verification failed");
        $finish;
    end

    function automatic logic [RATE_W-1:0] pick_rate(t_rate_style style);
        logic [RATE_W-1:0] r;
        case (style)
            RATES_LOSSY:      r = RATE_W'($urandom_range(32'h8000, 32'h10000));
            RATES_NEAR_UNITY: r = RATE_W'($urandom_range(32'hE000, 32'h12000));
            default: begin
                case ($urandom_range(0, 3))
                    0:       r = RATE_W'($urandom());
                    1:       r = '0;
                    2:       r = RATE_MAX;
                    default: r = RATE_W'($urandom_range(32'h4000, 32'h40000));
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [FEE_W-1:0] pick_fee();
        logic [FEE_W-1:0] f;
        case ($urandom_range(0, 9))
            6, 7:    f = $urandom_range(0, 32'h0000FFFF);
            8:       f = $urandom();
            9:       f = 32'hFFFF_FFFF;
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        int unsigned eff;
        eff = (cur_count > MAX_CURRENCIES) ? MAX_CURRENCIES : cur_count;
        if (eff == 0 || $urandom_range(0, 19) == 0) return NODE_W'($urandom_range(0, 127));
        return NODE_W'($urandom_range(0, eff - 1));
    endfunction

    // registers may only change while the block is idle
    task automatic program_block(logic [CNT_W-1:0] count, logic [START_W-1:0] start,
                                 logic [AMT_W-1:0] amount);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CUR_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(posedge i_clk);
        sb.write_register(CFG_CUR_COUNT, CFG_DATA_W'(count));
        i_cfg_index <= CFG_START;
        i_cfg_data  <= CFG_DATA_W'(start);
        @(posedge i_clk);
        sb.write_register(CFG_START, CFG_DATA_W'(start));
        i_cfg_index <= CFG_INIT_AMT;
        i_cfg_data  <= amount;
        @(posedge i_clk);
        sb.write_register(CFG_INIT_AMT, amount);
        i_cfg_we    <= 1'b0;
        cur_count = count;
        cfg_rounds++;
    endtask

    task automatic send_link(t_link beat, logic last);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_first_currency  <= beat.first;
        i_second_currency <= beat.second;
        i_forward_rate    <= beat.fwd_rate;
        i_forward_fee     <= beat.fwd_fee;
        i_backward_rate   <= beat.bwd_rate;
        i_backward_fee    <= beat.bwd_fee;
        i_last_link       <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_link(beat, last);
    endtask

    // hold the sender until every pending run has reported
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_link        beat;
        t_rate_style  style;
        int unsigned  graph_no;
        int unsigned  random_links;
        int unsigned  n;
        int unsigned  eff;
        logic [START_W-1:0] start;

        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: one currency, nothing held, self loop cannot grow
        send_link(t_link'{7'd0, 7'd0, RATE_2_0, 32'd0, RATE_2_0, 32'd0}, 1'b1);

        settle();
        program_block(8'd2, 7'd0, 32'h0064_0000);
        send_link(t_link'{7'd0, 7'd1, RATE_2_0, 32'd0, RATE_0_6, 32'd0}, 1'b1);
        send_link(t_link'{7'd0, 7'd1, RATE_2_0, 32'd0, RATE_0_4, 32'd0}, 1'b1);
        // zero rate, max rate behind max fee, fee equal to the amount
        send_link(t_link'{7'd0, 7'd1, 24'd0, 32'd0, RATE_MAX, 32'hFFFF_FFFF}, 1'b0);
        send_link(t_link'{7'd1, 7'd0, RATE_1_0, 32'd0, RATE_0_5, 32'h0064_0000}, 1'b1);

        // products saturate on both sides
        settle();
        program_block(8'd2, 7'd1, 32'hFFFF_FFFF);
        send_link(t_link'{7'd0, 7'd1, RATE_MAX, 32'd0, RATE_MAX, 32'd0}, 1'b1);

        // no currencies at all
        settle();
        program_block(8'd0, 7'd0, 32'h0064_0000);
        send_link(t_link'{7'd0, 7'd1, RATE_2_0, 32'd0, RATE_2_0, 32'd0}, 1'b1);

        // single currency: only the final check can see the self loop grow
        settle();
        program_block(8'd1, 7'd0, 32'h0064_0000);
        send_link(t_link'{7'd0, 7'd0, RATE_2_0, 32'd0, RATE_2_0, 32'd0}, 1'b1);

        // gain cycle through a currency beyond the count must be skipped
        settle();
        program_block(8'd4, 7'd0, 32'h000A_0000);
        send_link(t_link'{7'd0, 7'd1, RATE_1_0, 32'd0, RATE_1_0, 32'd0}, 1'b0);
        send_link(t_link'{7'd1, 7'd5, RATE_2_0, 32'd0, RATE_2_0, 32'd0}, 1'b0);
        send_link(t_link'{7'd1, 7'd2, RATE_1_0, 32'd0, RATE_0_5, 32'd0}, 1'b1);

        // start outside the count: nothing seeded
        settle();
        program_block(8'd4, 7'd9, 32'h000A_0000);
        send_link(t_link'{7'd0, 7'd1, RATE_2_0, 32'd0, RATE_2_0, 32'd0}, 1'b1);

        // count above the store size clamps to it
        settle();
        program_block(8'd255, 7'd127, 32'h000A_0000);
        send_link(t_link'{7'd127, 7'd126, RATE_1_5, 32'd0, RATE_0_75, 32'd0}, 1'b1);

        // three-currency loop, first profitable, then eaten by fees
        settle();
        program_block(8'd128, 7'd0, 32'h0032_0000);
        send_link(t_link'{7'd0, 7'd1, RATE_1_1, 32'd0, RATE_0_5, 32'd0}, 1'b0);
        send_link(t_link'{7'd1, 7'd2, RATE_1_1, 32'd0, RATE_0_5, 32'd0}, 1'b0);
        send_link(t_link'{7'd2, 7'd0, RATE_0_9, 32'd0, RATE_0_5, 32'd0}, 1'b1);
        send_link(t_link'{7'd0, 7'd1, RATE_1_1, 32'h0003_0000, RATE_0_5, 32'd0}, 1'b0);
        send_link(t_link'{7'd1, 7'd2, RATE_1_1, 32'h0003_0000, RATE_0_5, 32'd0}, 1'b0);
        send_link(t_link'{7'd2, 7'd0, RATE_0_9, 32'h0003_0000, RATE_0_5, 32'd0}, 1'b1);

        graph_no = 0;
        random_links = 0;
        while (random_links < RANDOM_LINKS) begin
            quiet = (graph_no >= 20 && graph_no < 30);
            style = t_rate_style'($urandom_range(0, 2));
            if (graph_no == 4) begin
                // overfill the link store; the extra links are dropped
                settle();
                program_block(8'd3, 7'd0, 32'h0032_0000);
                style = RATES_NEAR_UNITY;
                n = MAX_LINKS + 4;
            end else begin
                if (graph_no == 0 || $urandom_range(0, 1) == 0) begin
                    settle();
                    case ($urandom_range(0, 15))
                        0:       cur_count = 8'd0;
                        1:       cur_count = 8'd1;
                        2:       cur_count = CNT_W'($urandom_range(128, 255));
                        3:       cur_count = CNT_W'($urandom_range(13, 127));
                        default: cur_count = CNT_W'($urandom_range(2, 12));
                    endcase
                    eff = (cur_count > MAX_CURRENCIES) ? MAX_CURRENCIES : cur_count;
                    if (eff > 0 && $urandom_range(0, 7) != 0)
                        start = START_W'($urandom_range(0, eff - 1));
                    else
                        start = START_W'($urandom_range(0, 127));
                    case ($urandom_range(0, 9))
                        0:       program_block(cur_count, start, 32'd0);
                        1:       program_block(cur_count, start, 32'hFFFF_FFFF);
                        2:       program_block(cur_count, start, $urandom());
                        default: program_block(cur_count, start,
                                               {16'($urandom_range(1, 1000)), 16'($urandom())});
                    endcase
                end else if ($urandom_range(0, 7) == 0) begin
                    settle();
                end
                // long relaxation for wide counts, so keep those graphs tiny
                if (cur_count > 12)
                    n = $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(13, 24);
                else
                    n = $urandom_range(1, 12);
            end
            for (int unsigned i = 0; i < n; i++) begin
                beat.first    = pick_node();
                beat.second   = pick_node();
                beat.fwd_rate = pick_rate(style);
                beat.fwd_fee  = pick_fee();
                beat.bwd_rate = pick_rate(style);
                beat.bwd_fee  = pick_fee();
                send_link(beat, i == n - 1);
            end
            random_links += n;
            graph_no++;
        end
        quiet = 1'b0;

        settle();
        repeat (16) @(posedge i_clk);
        $display("%0d link beats over %0d runs checked, %0d runs flagged a gain cycle",
                 sb.links_taken, sb.runs_checked, sb.gain_runs);
        $display("%0d directed and random graphs, %0d register rounds, %0d mismatches",
                 graph_no + 12, cfg_rounds, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("exchange_gain_cycle_detect verification clean");
        end else begin
            $display("exchange_gain_cycle_detect verification failed");
        end
        $finish;
    end

endmodule

@@ exchange_gain_cycle_detect.f @@
rtl/core/ecd_pkg.sv
rtl/core/ecd_ram.sv
rtl/core/ecd_relax.sv
rtl/core/ecd_ctrl.sv
rtl/core/exchange_gain_cycle_detect.sv
rtl/core/ecd_checker.sv
sim/cycle_gain_scoreboard.sv
sim/tb_exchange_gain_cycle_detect.sv
